// ----- rtl/core/ppu_pkg.sv -----
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants for the picture register port.
// ----------------------------------------------------------------------------
package ppu_pkg;

   localparam int NameDepth   = 2048;
   localparam int ObjDepth    = 256;
   localparam int PalDepth    = 32;
   localparam int QueueDepth  = 2;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_STATUS = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   localparam logic [2:0] REG_CTRL   = 3'd0;
   localparam logic [2:0] REG_MASK   = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd2;
   localparam logic [2:0] REG_OADDR  = 3'd3;
   localparam logic [2:0] REG_ODATA  = 3'd4;
   localparam logic [2:0] REG_SCROLL = 3'd5;
   localparam logic [2:0] REG_ADDR   = 3'd6;
   localparam logic [2:0] REG_DATA   = 3'd7;

   localparam logic [1:0] MIR_HORIZ = 2'd0;
   localparam logic [1:0] MIR_VERT  = 2'd1;

   localparam logic [0:0] CSR_MIRROR = 1'd0;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] reg_sel;
      logic [7:0] wdata;
      logic [7:0] ext_rdata;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        ext_read;
      logic        ext_write;
      logic [13:0] ext_addr;
      logic [7:0]  ext_data;
      logic [14:0] video_addr;
      logic [2:0]  fine_x;
      logic [7:0]  control_byte;
      logic [7:0]  mask_byte;
   } rsp_type;

   // video memory target, classified in the back part
   typedef enum logic [1:0] {
      TGT_NAME = 2'd0,
      TGT_PAL  = 2'd1,
      TGT_EXT  = 2'd2
   } tgt_type;

   // classified word registered into the back part's stage 1
   typedef struct packed {
      req_type     req;
      tgt_type     tgt;
      logic [10:0] name_idx;
      logic [4:0]  pal_idx;
      logic [13:0] ext_addr;
   } cmd_type;

   function automatic logic [4:0] pal_index(input logic [13:0] a);
      logic [4:0] i;
      i = a[4:0];
      if (i[4] && i[1:0] == 2'b00) i[4] = 1'b0;
      return i;
   endfunction

endpackage

// ----- rtl/core/ppu_front.sv -----
// ----------------------------------------------------------------------------
// ppu_front
// Input stage: registers an accepted word into a small queue.
// ----------------------------------------------------------------------------
module ppu_front #(
   parameter int Depth = ppu_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ppu_pkg::req_type req_word,
   output logic             q_valid,
   input  logic             q_take,
   output ppu_pkg::req_type q_word
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   ppu_pkg::req_type mem_ff [Depth];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign req_stall = (cnt_ff == (AW+1)'(Depth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_valid && q_take;
   assign q_word    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ((wp_ff == AW'(Depth-1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = pop  ? ((rp_ff == AW'(Depth-1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= req_word;
   end
endmodule

// ----- rtl/core/ppu_back.sv -----
// ----------------------------------------------------------------------------
// ppu_back
// Executes words one at a time: classify + store read, then update.
// ----------------------------------------------------------------------------
module ppu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       mirroring,
   input  logic             q_valid,
   output logic             q_take,
   input  ppu_pkg::req_type q_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ppu_pkg::rsp_type rsp_word
);
   // scroll / register state
   logic [7:0]  ctrl_ff, mask_ff, stat_ff, oaddr_ff, rbuf_ff;
   logic [14:0] cur_ff, tmp_ff;
   logic [2:0]  fx_ff;
   logic        tog_ff;
   // clearing sweep for the name and object stores
   logic        clr_ff;
   logic [10:0] clr_idx_ff;
   logic [8:0]  oclr_idx_ff;

   logic [7:0] name_mem [ppu_pkg::NameDepth];
   logic [7:0] obj_mem  [ppu_pkg::ObjDepth];
   logic [7:0] pal_ff   [ppu_pkg::PalDepth];
   logic [7:0] name_rd_ff, obj_rd_ff;

   // stage 1 (fetch) and stage 2 (execute)
   logic              s1_ff;
   ppu_pkg::cmd_type  c_ff, cmd;
   logic              out_ff;
   ppu_pkg::rsp_type  out_word_ff, res;

   logic [13:0] a14, fa;
   logic        busy, do_exec;
   logic [14:0] step;

   // classify current address (cur is stable while a word sits in stage 1)
   always_comb begin
      a14 = cur_ff[13:0];
      fa  = a14;
      if (fa[13:12] == 2'b11) fa[12] = 1'b0;
      if (mirroring == ppu_pkg::MIR_HORIZ) begin
         fa[11] = 1'b0; fa[10] = a14[11] & (fa[13:12] == 2'b10);
         if (fa[13:12] != 2'b10) fa = a14;
      end else if (mirroring == ppu_pkg::MIR_VERT && fa[13:12] == 2'b10) begin
         fa[11] = 1'b0;
      end
      cmd          = '0;
      cmd.req      = q_word;
      cmd.pal_idx  = ppu_pkg::pal_index(a14);
      cmd.name_idx = fa[10:0];
      if (a14[13:8] == 6'h3F) begin
         cmd.tgt = ppu_pkg::TGT_PAL;
      end else if (fa[13:11] == 3'b100) begin
         cmd.tgt = ppu_pkg::TGT_NAME;
      end else begin
         cmd.tgt      = ppu_pkg::TGT_EXT;
         cmd.ext_addr = fa;
      end
   end

   assign busy    = s1_ff || clr_ff || (out_ff && rsp_stall);
   assign q_take  = q_valid && !busy;
   assign do_exec = s1_ff && !(out_ff && rsp_stall);
   assign step    = ctrl_ff[2] ? 15'd32 : 15'd1;
   assign rsp_valid = out_ff;
   assign rsp_word  = out_word_ff;

   always_ff @(posedge clock) begin
      if (q_take) begin
         c_ff       <= cmd;
         name_rd_ff <= name_mem[cmd.name_idx];
         obj_rd_ff  <= obj_mem[oaddr_ff];
      end
      if (clr_ff) begin
         name_mem[clr_idx_ff] <= '0;
         if (!oclr_idx_ff[8]) obj_mem[oclr_idx_ff[7:0]] <= '0;
      end else if (do_exec && c_ff.req.op == ppu_pkg::OP_WRITE) begin
         if (c_ff.req.reg_sel == ppu_pkg::REG_DATA && c_ff.tgt == ppu_pkg::TGT_NAME)
            name_mem[c_ff.name_idx] <= c_ff.req.wdata;
         if (c_ff.req.reg_sel == ppu_pkg::REG_ODATA)
            obj_mem[oaddr_ff] <= c_ff.req.wdata;
      end
      if (do_exec) out_word_ff <= res;
   end

   always_comb begin
      res = '0;
      if (c_ff.req.op == ppu_pkg::OP_READ) begin
         case (c_ff.req.reg_sel)
            ppu_pkg::REG_STATUS: res.read_data = stat_ff;
            ppu_pkg::REG_ODATA:  res.read_data = obj_rd_ff;
            ppu_pkg::REG_DATA: begin
               if (c_ff.tgt == ppu_pkg::TGT_PAL) res.read_data = pal_ff[c_ff.pal_idx];
               else                              res.read_data = rbuf_ff;
               if (c_ff.tgt == ppu_pkg::TGT_EXT) begin
                  res.ext_read = 1'b1; res.ext_addr = c_ff.ext_addr;
               end
            end
            default: ;
         endcase
      end else if (c_ff.req.op == ppu_pkg::OP_WRITE && c_ff.req.reg_sel == ppu_pkg::REG_DATA
                   && c_ff.tgt == ppu_pkg::TGT_EXT) begin
         res.ext_write = 1'b1; res.ext_addr = c_ff.ext_addr; res.ext_data = c_ff.req.wdata;
      end
      res.video_addr = cur_ff; res.fine_x = fx_ff;
      res.control_byte = ctrl_ff; res.mask_byte = mask_ff;
      // state after the word
      if (c_ff.req.op == ppu_pkg::OP_READ && c_ff.req.reg_sel == ppu_pkg::REG_DATA)
         res.video_addr = cur_ff + step;
      if (c_ff.req.op == ppu_pkg::OP_WRITE) begin
         case (c_ff.req.reg_sel)
            ppu_pkg::REG_CTRL: res.control_byte = c_ff.req.wdata;
            ppu_pkg::REG_MASK: res.mask_byte = c_ff.req.wdata;
            ppu_pkg::REG_SCROLL: if (!tog_ff) res.fine_x = c_ff.req.wdata[2:0];
            ppu_pkg::REG_ADDR:   if (tog_ff) res.video_addr = {tmp_ff[14:8], c_ff.req.wdata};
            ppu_pkg::REG_DATA:   res.video_addr = cur_ff + step;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0; mask_ff <= '0; stat_ff <= '0; oaddr_ff <= '0; rbuf_ff <= '0;
         cur_ff <= '0; tmp_ff <= '0; fx_ff <= '0; tog_ff <= 1'b0;
         clr_ff <= 1'b1; clr_idx_ff <= '0; oclr_idx_ff <= '0;
         s1_ff <= 1'b0; out_ff <= 1'b0;
         for (int i = 0; i < ppu_pkg::PalDepth; i++) pal_ff[i] <= '0;
      end else begin
         if (clr_ff) begin
            clr_idx_ff  <= clr_idx_ff + 1'b1;
            oclr_idx_ff <= oclr_idx_ff + 1'b1;
            if (clr_idx_ff == 11'(ppu_pkg::NameDepth - 1)) clr_ff <= 1'b0;
         end
         if (out_ff && !rsp_stall && !do_exec) out_ff <= 1'b0;
         if (q_take) s1_ff <= 1'b1;
         if (do_exec) begin
            s1_ff  <= 1'b0;
            out_ff <= 1'b1;
            cur_ff  <= res.video_addr;
            fx_ff   <= res.fine_x;
            ctrl_ff <= res.control_byte;
            mask_ff <= res.mask_byte;
            case (c_ff.req.op)
               ppu_pkg::OP_READ: begin
                  if (c_ff.req.reg_sel == ppu_pkg::REG_STATUS) begin
                     stat_ff[7] <= 1'b0; tog_ff <= 1'b0;
                  end
                  if (c_ff.req.reg_sel == ppu_pkg::REG_DATA) begin
                     if (c_ff.tgt == ppu_pkg::TGT_NAME) rbuf_ff <= name_rd_ff;
                     else if (c_ff.tgt == ppu_pkg::TGT_EXT) rbuf_ff <= c_ff.req.ext_rdata;
                  end
               end
               ppu_pkg::OP_WRITE: begin
                  case (c_ff.req.reg_sel)
                     ppu_pkg::REG_CTRL:  tmp_ff[11:10] <= c_ff.req.wdata[1:0];
                     ppu_pkg::REG_OADDR: oaddr_ff <= c_ff.req.wdata;
                     ppu_pkg::REG_ODATA: oaddr_ff <= oaddr_ff + 1'b1;
                     ppu_pkg::REG_SCROLL: begin
                        if (tog_ff) begin
                           tmp_ff[14:12] <= c_ff.req.wdata[2:0];
                           tmp_ff[9:5]   <= c_ff.req.wdata[7:3];
                        end else tmp_ff[4:0] <= c_ff.req.wdata[7:3];
                        tog_ff <= !tog_ff;
                     end
                     ppu_pkg::REG_ADDR: begin
                        if (tog_ff) tmp_ff[7:0] <= c_ff.req.wdata;
                        else tmp_ff[14:8] <= {1'b0, c_ff.req.wdata[5:0]};
                        tog_ff <= !tog_ff;
                     end
                     ppu_pkg::REG_DATA:
                        if (c_ff.tgt == ppu_pkg::TGT_PAL) pal_ff[c_ff.pal_idx] <= c_ff.req.wdata;
                     default: ;
                  endcase
               end
               ppu_pkg::OP_STATUS: stat_ff <= c_ff.req.wdata;
               default: ;
            endcase
         end
      end
   end
endmodule

// ----- rtl/core/ppu_register_port_vram_access.sv -----
// ----------------------------------------------------------------------------
// ppu_register_port_vram_access
// CPU-side picture register port with scroll registers and video memory.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one word per bus access: op (read, write, status load),
//  reg_sel, wdata and ext_rdata (byte external memory holds at the current
//  video address). rsp_* returns one word per request, in order, with the
//  read byte, any external access and the scroll/control state after it.
//  The p* signals form an APB-style csr port; register 0 (addresses 0 to 3)
//  is mirroring mode. A front queue of two words accepts requests; the back
//  part executes a word as a store read, then an update, and takes a new
//  word only once the last has executed. rsp_valid rises when the word is
//  registered at the output, after the queue and stage 1; stage 1 serves
//  the synchronous name/object store read. Reset clears the control and
//  state registers, then sweeps the 2048-entry name store and 256-entry
//  object store, one entry a cycle; no word executes until the sweep ends
//  (requests still queue; csr writes are taken). A stalled response holds
//  its word; the back part waits, the queue fills and then req_stall rises.
// ----------------------------------------------------------------------------
module ppu_register_port_vram_access #(
   parameter int QueueDepth = ppu_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ppu_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ppu_pkg::rsp_type rsp_word,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   logic [1:0] mir_ff;
   logic q_valid, q_take;
   ppu_pkg::req_type q_word;

   assign pready = 1'b1;
   // register 0 (addresses 0 to 3) only; other addresses read zero
   assign prdata = (paddr[2] == ppu_pkg::CSR_MIRROR) ? {30'd0, mir_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) mir_ff <= ppu_pkg::MIR_HORIZ;
      else if (psel && penable && pwrite && paddr[2] == ppu_pkg::CSR_MIRROR)
         mir_ff <= pwdata[1:0];
   end

   ppu_front #(.Depth(QueueDepth)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .q_valid, .q_take, .q_word
   );

   ppu_back u_back (
      .clock, .reset, .mirroring(mir_ff), .q_valid, .q_take, .q_word,
      .rsp_valid, .rsp_stall, .rsp_word
   );

   // a response word never reports an external read and write together
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.ext_read ? !rsp_word.ext_write : 1'b1)
      else $error("ext read and write together");
   assert property (@(posedge clock) disable iff (reset)
      !rsp_word.ext_write && rsp_valid |-> rsp_word.ext_data == 8'd0)
      else $error("ext data without write");
   assert property (@(posedge clock) disable iff (reset)
      $past(q_take) |-> !q_take)
      else $error("back part took two words in a row");
endmodule
